@@ src/hstg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hstg_pkg
// shared types and constants of the heading/speed trajectory generator
// ----------------------------------------------------------------------------
package hstg_pkg;

  localparam int unsigned CORDIC_STEPS = 18;
  localparam logic signed [27:0] DEG90  = 28'sd5898240;
  localparam logic signed [27:0] DEG180 = 28'sd11796480;
  localparam logic signed [27:0] DEG360 = 28'sd23592960;
  localparam logic [26:0] RAD_PER_DEG_Q32 = 27'd74961321;
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam logic signed [26:0] VEL_LIMIT = 27'sd65536000;
  localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;

  typedef enum logic [0:0] {
    REG_START_X = 1'b0,
    REG_START_Y = 1'b1
  } reg_index_t;

  function automatic logic [21:0] atan_entry(input logic [4:0] i);
    logic [21:0] r;
    begin
      case (i)
        5'd0:  r = 22'd2949120;
        5'd1:  r = 22'd1740967;
        5'd2:  r = 22'd919879;
        5'd3:  r = 22'd466945;
        5'd4:  r = 22'd234379;
        5'd5:  r = 22'd117304;
        5'd6:  r = 22'd58666;
        5'd7:  r = 22'd29335;
        5'd8:  r = 22'd14668;
        5'd9:  r = 22'd7334;
        5'd10: r = 22'd3667;
        5'd11: r = 22'd1833;
        5'd12: r = 22'd917;
        5'd13: r = 22'd458;
        5'd14: r = 22'd229;
        5'd15: r = 22'd115;
        5'd16: r = 22'd57;
        5'd17: r = 22'd29;
        default: r = 22'd0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ src/hstg_serial_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hstg_serial_mul
// unsigned shift-and-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module hstg_serial_mul #(
  parameter int unsigned AW = 48,
  parameter int unsigned BW = 48
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [AW-1:0]      a,
  input  wire logic [BW-1:0]      b,
  output logic                    done,
  output logic [AW+BW-1:0]        prod
);

  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW-1:0] mcand;
  logic [BW-1:0] mplier;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [AW:0]   hi_sum;

  assign hi_sum = {1'b0, prod[AW+BW-1:BW]} + (mplier[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        mcand  <= a;
        mplier <= b;
        prod   <= '0;
      end else if (busy) begin
        prod   <= {hi_sum, prod[BW-1:1]};
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ src/hstg_serial_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hstg_serial_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hstg_serial_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 48
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [DW:0]   rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW+1:0] trial;
  logic [DW:0]   shifted;

  assign shifted = {rem[DW-1:0], quo[NW-1]};
  assign trial   = {1'b0, shifted} - {2'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= den;
        quo  <= num;
      end else if (busy) begin
        if (!trial[DW+1]) begin
          rem <= trial[DW:0];
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ src/hstg_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hstg_cordic
// iterative rotation cordic on degrees, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module hstg_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [27:0] angle,
  output logic                    done,
  output logic signed [33:0]      cos_q30,
  output logic signed [33:0]      sin_q30
);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [27:0] z;
  logic signed [27:0] z0;
  logic [4:0]         step;
  logic               busy;
  logic               flip;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [27:0] at;

  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = $signed({6'b0, hstg_pkg::atan_entry(step)});
  assign z0 = (angle > hstg_pkg::DEG180) ? angle - hstg_pkg::DEG360 : angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= 34'(hstg_pkg::CORDIC_GAIN_Q30);
        y    <= '0;
        if (z0 > hstg_pkg::DEG90) begin
          z <= z0 - hstg_pkg::DEG180; flip <= 1'b1;
        end else if (z0 < -hstg_pkg::DEG90) begin
          z <= z0 + hstg_pkg::DEG180; flip <= 1'b1;
        end else begin
          z <= z0; flip <= 1'b0;
        end
      end else if (busy) begin
        if (!z[27]) begin
          x <= x - ys; y <= y + xs; z <= z - at;
        end else begin
          x <= x + ys; y <= y - xs; z <= z + at;
        end
        step <= step + 1'b1;
        if (step == 5'(hstg_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cos_q30 = flip ? -x : x;
  assign sin_q30 = flip ? -y : y;

endmodule
`default_nettype wire

@@ src/heading_speed_trajectory_generator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heading_speed_trajectory_generator_unit
// dead-reckoning reference generator: heading/speed to position, velocity,
// acceleration
// ----------------------------------------------------------------------------
// sequence per input transfer: wrap, cordic, then two velocity products, two
// position products and two divides, one bit per cycle each; the divides are
// skipped on a zero time step; one item at a time, a new item is taken only
// once the last result has been accepted
// reset: synchronous, clears start point, position, time and velocity state
module heading_speed_trajectory_generator_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [47:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [25:0] heading_deg,
  input  wire logic signed [26:0] speed,
  input  wire logic [47:0]        time_now,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [47:0]      pos_x,
  output logic signed [47:0]      pos_y,
  output logic signed [26:0]      vel_x,
  output logic signed [26:0]      vel_y,
  output logic signed [31:0]      acc_x,
  output logic signed [31:0]      acc_y,
  output logic [18:0]             heading_east,
  output logic                    zero_step
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_CORDIC, S_VMUL, S_VEL, S_PMUL, S_POS, S_DIV, S_ACC, S_OUT
  } state_t;

  state_t state;
  logic   axis;

  logic signed [47:0] start_x;
  logic signed [47:0] start_y;
  logic               started;
  logic signed [47:0] cur_x;
  logic signed [47:0] cur_y;
  logic [47:0]        prev_time;
  logic signed [26:0] prev_vel_x;
  logic signed [26:0] prev_vel_y;

  logic signed [26:0] spd;
  logic [47:0]        now;
  logic signed [27:0] d;
  logic signed [48:0] dt;
  logic signed [33:0] cs_c;
  logic signed [33:0] cs_s;

  // wrap: 90 - heading mod 360
  logic signed [27:0] d_raw;
  logic signed [27:0] d_wrap;
  assign d_raw  = hstg_pkg::DEG90 - 28'(heading_deg);
  assign d_wrap = (d_raw >= hstg_pkg::DEG360) ? d_raw - hstg_pkg::DEG360 :
                  (d_raw < -hstg_pkg::DEG360) ? d_raw + (hstg_pkg::DEG360 <<< 1) :
                  (d_raw < 0) ? d_raw + hstg_pkg::DEG360 : d_raw;

  // cordic
  logic               cor_start;
  logic               cor_done;
  logic signed [33:0] cor_c;
  logic signed [33:0] cor_s;
  hstg_cordic u_cordic (
    .clk, .rst, .start(cor_start), .angle(d),
    .done(cor_done), .cos_q30(cor_c), .sin_q30(cor_s)
  );

  // shared multiplier, magnitudes
  logic        mul_start;
  logic        mul_done;
  logic [47:0] mul_a;
  logic [47:0] mul_b;
  logic [95:0] mul_p;
  hstg_serial_mul #(.AW(48), .BW(48)) u_mul (
    .clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  logic        div_start;
  logic        div_done;
  logic [47:0] div_n;
  logic [47:0] div_d;
  logic [47:0] div_q;
  hstg_serial_div #(.NW(48), .DW(48)) u_div (
    .clk, .rst, .start(div_start), .num(div_n), .den(div_d),
    .done(div_done), .quo(div_q)
  );

  logic               neg;
  logic signed [33:0] trig;
  logic signed [26:0] vel_cur;
  logic signed [47:0] pos_cur;
  logic signed [26:0] pvel_cur;
  logic [48:0]        dt_mag;

  assign trig     = axis ? cs_s : cs_c;
  assign vel_cur  = axis ? vel_y : vel_x;
  assign pos_cur  = axis ? cur_y : cur_x;
  assign pvel_cur = axis ? prev_vel_y : prev_vel_x;
  assign dt_mag   = dt[48] ? 49'(-dt) : 49'(dt);

  // velocity rounding
  logic [62:0] vprod_mag;
  logic signed [63:0] vprod;
  logic signed [33:0] vq;
  logic signed [26:0] vsat;
  assign vprod_mag = mul_p[62:0];
  assign vprod = neg ? -$signed({1'b0, vprod_mag}) : $signed({1'b0, vprod_mag});
  assign vq    = 34'((vprod + 64'sd536870912) >>> 30);
  assign vsat  = (vq > 34'(hstg_pkg::VEL_LIMIT)) ? hstg_pkg::VEL_LIMIT :
                 (vq < -34'(hstg_pkg::VEL_LIMIT)) ? -hstg_pkg::VEL_LIMIT : 27'(vq);

  // position step
  logic [80:0] inc;
  logic signed [82:0] psum;
  logic signed [47:0] psat;
  assign inc  = mul_p[95:16] + {79'b0, mul_p[15]};
  assign psum = neg ? 83'(pos_cur) - $signed({2'b0, inc}) : 83'(pos_cur) + $signed({2'b0, inc});
  assign psat = (psum > 83'(hstg_pkg::POS_MAX)) ? hstg_pkg::POS_MAX :
                (psum < 83'(hstg_pkg::POS_MIN)) ? hstg_pkg::POS_MIN : 48'(psum);

  // acceleration
  logic signed [27:0] dv;
  logic [27:0]        dv_mag;
  logic signed [48:0] qs;
  logic signed [31:0] asat;
  assign dv     = 28'(vel_cur) - 28'(pvel_cur);
  assign dv_mag = dv[27] ? 28'(-dv) : 28'(dv);
  assign qs     = neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign asat   = (qs > 49'sd2147483647) ? 32'sh7FFF_FFFF :
                  (qs < -49'sd2147483648) ? 32'sh8000_0000 : 32'(qs);

  always_comb begin
    cor_start = (state == S_WRAP);
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_n = {4'b0, dv_mag, 16'b0};
    div_d = dt_mag[47:0];
    unique case (state)
      S_VMUL: begin
        mul_start = 1'b1;
        mul_a = {21'b0, spd[26] ? 27'(-spd) : 27'(spd)};
        mul_b = {14'b0, trig[33] ? 34'(-trig) : 34'(trig)};
      end
      S_PMUL: begin
        mul_start = 1'b1;
        mul_a = dt_mag[47:0];
        mul_b = {21'b0, vel_cur[26] ? 27'(-vel_cur) : 27'(vel_cur)};
      end
      S_DIV: div_start = 1'b1;
      default: ;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      axis       <= 1'b0;
      start_x    <= '0;
      start_y    <= '0;
      started    <= 1'b0;
      cur_x      <= '0;
      cur_y      <= '0;
      prev_time  <= '0;
      prev_vel_x <= '0;
      prev_vel_y <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          hstg_pkg::REG_START_X: start_x <= cfg_data;
          hstg_pkg::REG_START_Y: start_y <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          spd <= speed;
          now <= time_now;
          d   <= d_wrap;
          dt  <= $signed({1'b0, time_now}) - $signed({1'b0, prev_time});
          if (!started) begin
            cur_x   <= start_x;
            cur_y   <= start_y;
            started <= 1'b1;
          end
          state <= S_WRAP;
        end
        S_WRAP: begin
          heading_east <= 19'((59'(d) * 59'(hstg_pkg::RAD_PER_DEG_Q32)) >> 32);
          state <= S_CORDIC;
        end
        S_CORDIC: if (cor_done) begin
          cs_c  <= cor_c;
          cs_s  <= cor_s;
          axis  <= 1'b0;
          state <= S_VMUL;
        end
        S_VMUL: begin
          neg   <= spd[26] ^ trig[33];
          state <= S_VEL;
        end
        S_VEL: if (mul_done) begin
          if (axis) vel_y <= vsat; else vel_x <= vsat;
          if (axis) begin
            axis <= 1'b0; state <= S_PMUL;
          end else begin
            axis <= 1'b1; state <= S_VMUL;
          end
        end
        S_PMUL: begin
          neg   <= dt[48] ^ vel_cur[26];
          state <= S_POS;
        end
        S_POS: if (mul_done) begin
          if (vel_cur != 0 && dt != 0) begin
            if (axis) cur_y <= psat; else cur_x <= psat;
          end
          if (axis) begin
            axis <= 1'b0;
            if (dt == 0) begin
              acc_x <= '0; acc_y <= '0; zero_step <= 1'b1;
              state <= S_OUT;
            end else begin
              zero_step <= 1'b0;
              state <= S_DIV;
            end
          end else begin
            axis <= 1'b1; state <= S_PMUL;
          end
        end
        S_DIV: begin
          neg   <= dv[27] ^ dt[48];
          state <= S_ACC;
        end
        S_ACC: if (div_done) begin
          if (axis) acc_y <= asat; else acc_x <= asat;
          if (axis) begin
            axis <= 1'b0; state <= S_OUT;
          end else begin
            axis <= 1'b1; state <= S_DIV;
          end
        end
        S_OUT: if (out_ready) begin
          prev_time  <= now;
          prev_vel_x <= vel_x;
          prev_vel_y <= vel_y;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pos_x = cur_x;
  assign pos_y = cur_y;

endmodule
`default_nettype wire
